[rtl/core/opr_pkg.sv]
// ============================================================================
// opr_pkg: shared definitions for the orthogonal polynomial recurrence
// Field widths, family codes, Q32.32 limits and parameter defaults.
// ============================================================================
package opr_pkg;

    localparam int MAX_DEGREE_DEF = 15;
    localparam int MAX_ORDER_DEF  = 15;

    localparam int KIND_W   = 2;
    localparam int DEGREE_W = 4;
    localparam int ORDER_W  = 4;
    localparam int ARG_W    = 32;
    localparam int VALUE_W  = 64;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    localparam logic [KIND_W-1:0] KIND_LEGENDRE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HERMITE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LAGUERRE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;

    localparam logic [VALUE_W-1:0] ONE_Q = 64'h0000_0001_0000_0000;
    localparam logic [VALUE_W-1:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] Q_MIN = 64'h8000_0000_0000_0000;

endpackage

[rtl/core/orthogonal_polynomial_recurrence.sv]
// ============================================================================
// orthogonal_polynomial_recurrence
// Legendre, Hermite and associated Laguerre values by three-term recurrence
// on one shared 32x32 multiplier and one saturating subtractor.
// ============================================================================
//  channel  | dir | tdata                                    | tuser
//  s_axis   | in  | [3:0] degree, [7:4] order, [39:8] arg    | [1:0] kind
//  m_axis   | out | [63:0] value (Q32.32)                    | [0] overflow
//
//  Each Q32.32 multiply on the shared 32x32 multiplier runs operand setup
//  (with rounding bias), four partial products, then sign and saturate.
//  A recurrence step runs COEF, TMUL, UMUL, DSUB, RMUL for Legendre and
//  Laguerre (COEF as a subtract), TMUL, UMUL, DSUB for Hermite; degrees 0
//  and 1 skip the recurrence. s_axis_tready is high only when idle.
//  The result register lets a new beat in while the last result waits.
//  rst_n clears all state asynchronously.
// ============================================================================
module orthogonal_polynomial_recurrence #(
    parameter int MAX_DEGREE = opr_pkg::MAX_DEGREE_DEF,
    parameter int MAX_ORDER  = opr_pkg::MAX_ORDER_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [opr_pkg::S_TDATA_W-1:0] s_axis_tdata,   // degree, order, arg
    input  logic [opr_pkg::KIND_W-1:0]    s_axis_tuser,   // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [opr_pkg::M_TDATA_W-1:0] m_axis_tdata,   // value
    output logic                          m_axis_tuser    // overflow
);
    import opr_pkg::*;

    localparam int IW = $clog2(MAX_DEGREE + 1);
    localparam int MW = $clog2(MAX_ORDER + 2);
    localparam int KW = $clog2(2 * MAX_DEGREE + MAX_ORDER + 1);

    localparam logic [2:0] UOP_COEF = 3'd0;
    localparam logic [2:0] UOP_TMUL = 3'd1;
    localparam logic [2:0] UOP_UMUL = 3'd2;
    localparam logic [2:0] UOP_DSUB = 3'd3;
    localparam logic [2:0] UOP_RMUL = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_MFIN,
        ST_DONE
    } state_t;

    function automatic logic [VALUE_W:0] sat_sub(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
        logic [VALUE_W-1:0] d;
        logic               o;
        d = a - b;
        o = (a[VALUE_W-1] != b[VALUE_W-1]) && (d[VALUE_W-1] != a[VALUE_W-1]);
        return {o, o ? (a[VALUE_W-1] ? Q_MIN : Q_MAX) : d};
    endfunction

    logic [31:0] recip_tab [MAX_DEGREE+1];

    for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_recip
        localparam logic [63:0] RV = ((64'd1 << 32) + g / 2) / ((g < 2) ? 2 : g);
        assign recip_tab[g] = RV[31:0];
    end

    state_t              state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [IW-1:0]       n_reg, n_next;
    logic [MW-1:0]       m_reg, m_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [2:0]          uop_reg, uop_next;
    logic [VALUE_W-1:0]  x_reg, x_next;
    logic [VALUE_W-1:0]  p0_reg, p0_next;
    logic [VALUE_W-1:0]  p1_reg, p1_next;
    logic [VALUE_W-1:0]  w_reg, w_next;
    logic [VALUE_W-1:0]  t_reg, t_next;
    logic [VALUE_W-1:0]  u_reg, u_next;
    logic                ov_reg, ov_next;
    logic [VALUE_W-1:0]  ma_reg, ma_next;
    logic [VALUE_W-1:0]  mb_reg, mb_next;
    logic                neg_reg, neg_next;
    logic [127:0]        acc_reg, acc_next;
    logic [1:0]          ph_reg, ph_next;
    logic [VALUE_W-1:0]  res_val_reg, res_val_next;
    logic                res_ov_reg, res_ov_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_val_reg, out_val_next;
    logic                out_ov_reg, out_ov_next;

    logic [7:0]          deg8, ord8, n8, m8;
    logic [VALUE_W-1:0]  x_in;
    logic [KW-1:0]       m_in_k;
    logic [VALUE_W:0]    lag_init;
    logic [VALUE_W-1:0]  p1_init;
    logic                p1_init_ov;

    logic                is_herm, is_lag;
    logic [KW-1:0]       i_k, m_k, k1, k2;
    logic [VALUE_W-1:0]  opa, opb;
    logic                is_sub;
    logic [VALUE_W:0]    sub_res;

    logic [31:0]         pa, pb;
    logic [63:0]         pp;
    logic [127:0]        pp_sh;
    logic [VALUE_W-1:0]  mr, lim, mul_val;
    logic                mul_ov;

    logic                wb_en, wb_ov;
    logic [VALUE_W-1:0]  wb_val;
    logic                wb_nx;

    assign deg8 = 8'(s_axis_tdata[3:0]);
    assign ord8 = 8'(s_axis_tdata[7:4]);
    assign n8   = (deg8 > 8'(MAX_DEGREE)) ? 8'(MAX_DEGREE) : deg8;
    assign m8   = (ord8 > 8'(MAX_ORDER)) ? 8'(MAX_ORDER) : ord8;
    assign x_in = {{24{s_axis_tdata[39]}}, s_axis_tdata[39:8], 8'h00};

    assign m_in_k   = KW'(m8) + KW'(1);
    assign lag_init = sat_sub(64'(m_in_k) << 32, x_in);

    always_comb
    begin
        p1_init    = x_in;
        p1_init_ov = 1'b0;
        case (s_axis_tuser)
            KIND_LEGENDRE: p1_init = x_in;
            KIND_HERMITE:  p1_init = {x_in[VALUE_W-2:0], 1'b0};
            KIND_LAGUERRE:
            begin
                p1_init    = lag_init[VALUE_W-1:0];
                p1_init_ov = lag_init[VALUE_W];
            end
            default:       p1_init = '0;
        endcase
    end

    assign is_herm = (kind_reg == KIND_HERMITE);
    assign is_lag  = (kind_reg == KIND_LAGUERRE);
    assign i_k     = KW'(i_reg);
    assign m_k     = is_lag ? KW'(m_reg) : '0;
    assign k1      = (i_k << 1) + m_k - KW'(1);
    assign k2      = is_herm ? ((i_k - KW'(1)) << 1) : (i_k + m_k - KW'(1));

    always_comb
    begin
        opa    = w_reg;
        opb    = p1_reg;
        is_sub = 1'b0;
        case (uop_reg)
            UOP_COEF:
            begin
                opa    = 64'(k1) << 32;
                opb    = x_reg;
                is_sub = is_lag;
            end
            UOP_TMUL:
            begin
                opa = is_herm ? {x_reg[VALUE_W-2:0], 1'b0} : w_reg;
                opb = p1_reg;
            end
            UOP_UMUL:
            begin
                opa = 64'(k2) << 32;
                opb = p0_reg;
            end
            UOP_DSUB:
            begin
                opa    = t_reg;
                opb    = u_reg;
                is_sub = 1'b1;
            end
            UOP_RMUL:
            begin
                opa = w_reg;
                opb = {32'h0, recip_tab[i_reg]};
            end
            default:
            begin
                opa = w_reg;
                opb = p1_reg;
            end
        endcase
    end

    assign sub_res = sat_sub(opa, opb);

    assign pa = ph_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign pb = ph_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp = 64'(pa) * 64'(pb);

    always_comb
    begin
        case (ph_reg)
            2'd0:    pp_sh = 128'(pp);
            2'd3:    pp_sh = 128'(pp) << 64;
            default: pp_sh = 128'(pp) << 32;
        endcase
    end

    assign mr      = acc_reg[95:32];
    assign lim     = neg_reg ? Q_MIN : Q_MAX;
    assign mul_ov  = (|acc_reg[127:96]) || (mr > lim);
    assign mul_val = mul_ov ? (neg_reg ? Q_MIN : Q_MAX) : (neg_reg ? (64'd0 - mr) : mr);

    always_comb
    begin
        wb_en  = 1'b0;
        wb_val = mul_val;
        wb_ov  = mul_ov;
        if (state_reg == ST_EXEC && is_sub)
        begin
            wb_en  = 1'b1;
            wb_val = sub_res[VALUE_W-1:0];
            wb_ov  = sub_res[VALUE_W];
        end
        else if (state_reg == ST_MFIN)
        begin
            wb_en = 1'b1;
        end
    end

    assign wb_nx = (uop_reg == UOP_RMUL) || (uop_reg == UOP_DSUB && is_herm);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        i_next         = i_reg;
        uop_next       = uop_reg;
        x_next         = x_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        w_next         = w_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        ov_next        = ov_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        ph_next        = ph_reg;
        res_val_next   = res_val_reg;
        res_ov_next    = res_ov_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_ov_next    = out_ov_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    kind_next = s_axis_tuser;
                    n_next    = n8[IW-1:0];
                    m_next    = m8[MW-1:0];
                    x_next    = x_in;
                    p0_next   = ONE_Q;
                    p1_next   = p1_init;
                    ov_next   = p1_init_ov;
                    i_next    = IW'(2);
                    uop_next  = (s_axis_tuser == KIND_HERMITE) ? UOP_TMUL : UOP_COEF;
                    if (s_axis_tuser == KIND_UNUSED)
                    begin
                        res_val_next = '0;
                        res_ov_next  = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else if (n8 == 8'd0)
                    begin
                        res_val_next = ONE_Q;
                        res_ov_next  = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else if (n8 == 8'd1)
                    begin
                        res_val_next = p1_init;
                        res_ov_next  = p1_init_ov;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (!is_sub)
                begin
                    ma_next    = opa[VALUE_W-1] ? (64'd0 - opa) : opa;
                    mb_next    = opb[VALUE_W-1] ? (64'd0 - opb) : opb;
                    neg_next   = opa[VALUE_W-1] ^ opb[VALUE_W-1];
                    acc_next   = 128'h8000_0000;
                    ph_next    = 2'd0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_next = acc_reg + pp_sh;
                ph_next  = ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    state_next = ST_MFIN;
                end
            end
            ST_MFIN:
            begin
                state_next = ST_EXEC;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_val_reg;
                    out_ov_next    = res_ov_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wb_en)
        begin
            ov_next = ov_reg | wb_ov;
            if (wb_nx)
            begin
                p0_next = p1_reg;
                p1_next = wb_val;
                if (i_reg == n_reg)
                begin
                    res_val_next = wb_val;
                    res_ov_next  = ov_reg | wb_ov;
                    state_next   = ST_DONE;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    uop_next   = is_herm ? UOP_TMUL : UOP_COEF;
                    state_next = ST_EXEC;
                end
            end
            else
            begin
                case (uop_reg)
                    UOP_TMUL: t_next = wb_val;
                    UOP_UMUL: u_next = wb_val;
                    default:  w_next = wb_val;
                endcase
                uop_next   = uop_reg + 3'd1;
                state_next = ST_EXEC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= '0;
            n_reg         <= '0;
            m_reg         <= '0;
            i_reg         <= '0;
            uop_reg       <= UOP_COEF;
            x_reg         <= '0;
            p0_reg        <= '0;
            p1_reg        <= '0;
            w_reg         <= '0;
            t_reg         <= '0;
            u_reg         <= '0;
            ov_reg        <= 1'b0;
            ma_reg        <= '0;
            mb_reg        <= '0;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            ph_reg        <= '0;
            res_val_reg   <= '0;
            res_ov_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_val_reg   <= '0;
            out_ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            n_reg         <= n_next;
            m_reg         <= m_next;
            i_reg         <= i_next;
            uop_reg       <= uop_next;
            x_reg         <= x_next;
            p0_reg        <= p0_next;
            p1_reg        <= p1_next;
            w_reg         <= w_next;
            t_reg         <= t_next;
            u_reg         <= u_next;
            ov_reg        <= ov_next;
            ma_reg        <= ma_next;
            mb_reg        <= mb_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            ph_reg        <= ph_next;
            res_val_reg   <= res_val_next;
            res_ov_reg    <= res_ov_next;
            out_valid_reg <= out_valid_next;
            out_val_reg   <= out_val_next;
            out_ov_reg    <= out_ov_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_val_reg;
    assign m_axis_tuser  = out_ov_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC || state_reg == ST_MUL || state_reg == ST_MFIN)
        |-> (i_reg >= IW'(2)) && (i_reg <= n_reg) && (uop_reg <= UOP_RMUL))
        else $error("recurrence step index or micro-op out of range");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside completion");

    a_mul_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MFIN) |-> $past(state_reg == ST_MUL) && ph_reg == 2'd0)
        else $error("multiply finished without four partial products");

endmodule
